[rtl/lpws_pkg.sv]
// ----------------------------------------------------------------------------
// lpws_pkg
// Shared types and constants of the LED pulse-width serializer.
// ----------------------------------------------------------------------------
package lpws_pkg;

    localparam int TICK_W   = 11;
    localparam int BYTE_W   = 8;
    localparam int BITCNT_W = 3;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REGIDX_W = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [REGIDX_W-1:0] REG_ONE_HIGH       = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_ONE_LOW        = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_ONE_LOW_LAST   = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_ZERO_HIGH      = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_ZERO_LOW       = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_ZERO_LOW_LAST  = 3'd5;

    localparam logic [TICK_W-1:0] RST_ONE_HIGH      = 11'd80;
    localparam logic [TICK_W-1:0] RST_ONE_LOW       = 11'd45;
    localparam logic [TICK_W-1:0] RST_ONE_LOW_LAST  = 11'd45;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH     = 11'd40;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW      = 11'd85;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW_LAST = 11'd85;

    localparam logic [BITCNT_W-1:0] FIRST_BIT_LEFT = 3'd7;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_LOAD = 1'b1
    } req_t;

    typedef struct packed {
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] one_low_last;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] zero_low_last;
    } cfg_t;

    typedef struct packed {
        req_t              kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } cmd_t;

endpackage

[rtl/lpws_front.sv]
// ----------------------------------------------------------------------------
// lpws_front
// Accepts items, classifies them into tick / load commands and holds them
// in a short queue for the back end.
// ----------------------------------------------------------------------------
module lpws_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [lpws_pkg::BYTE_W-1:0] s_data_byte,
    input  logic                      s_last_byte,
    output logic                      q_valid,
    output lpws_pkg::cmd_t            q_cmd,
    input  logic                      q_pop
);
    import lpws_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    cmd_t              cmd_in;

    always_comb begin
        cmd_in.kind = s_req_type ? REQ_LOAD : REQ_TICK;
        // payload only matters on a load
        cmd_in.data = s_req_type ? s_data_byte : '0;
        cmd_in.last = s_req_type & s_last_byte;
    end

    assign s_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push    = s_valid & s_ready;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

[rtl/lpws_back.sv]
// ----------------------------------------------------------------------------
// lpws_back
// Waveform engine: holding register, bit shifter and phase counter. Runs one
// queued command per cycle unless the output stalls, registering each result.
// ----------------------------------------------------------------------------
module lpws_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  lpws_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  lpws_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_line_level,
    output logic           m_accepted,
    output logic           m_busy_res,
    output logic           m_frame_done
);
    import lpws_pkg::*;

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        at_least_one = (v == '0) ? TICK_W'(1) : v;
    endfunction

    logic [BYTE_W-1:0]   shift_byte_reg, shift_byte_next;
    logic [BITCNT_W-1:0] bit_left_reg, bit_left_next;
    logic                in_high_reg, in_high_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;
    logic                sending_reg, sending_next;
    logic                sending_last_reg, sending_last_next;
    logic [BYTE_W-1:0]   pend_byte_reg, pend_byte_next;
    logic                pend_full_reg, pend_full_next;
    logic                pend_last_reg, pend_last_next;

    logic m_valid_reg, m_valid_next;
    logic m_line_level_reg, m_accepted_reg, m_busy_res_reg, m_frame_done_reg;
    logic level, acc, done;

    assign q_pop = q_valid & (~m_valid_reg | m_ready);

    always_comb begin
        shift_byte_next   = shift_byte_reg;
        bit_left_next     = bit_left_reg;
        in_high_next      = in_high_reg;
        ticks_next        = ticks_reg;
        sending_next      = sending_reg;
        sending_last_next = sending_last_reg;
        pend_byte_next    = pend_byte_reg;
        pend_full_next    = pend_full_reg;
        pend_last_next    = pend_last_reg;
        level = 1'b0;
        acc   = 1'b1;
        done  = 1'b0;

        if (q_cmd.kind == REQ_LOAD) begin
            if (pend_full_reg) begin
                acc = 1'b0;
            end else begin
                pend_byte_next = q_cmd.data;
                pend_last_next = q_cmd.last;
                pend_full_next = 1'b1;
            end
        end else begin
            // idle line picks up the pending byte in this same tick
            if (!sending_reg && pend_full_reg) begin
                shift_byte_next   = pend_byte_reg;
                sending_last_next = pend_last_reg;
                pend_full_next    = 1'b0;
                sending_next      = 1'b1;
                bit_left_next     = FIRST_BIT_LEFT;
                in_high_next      = 1'b1;
                ticks_next        = at_least_one(pend_byte_reg[BYTE_W-1] ?
                                                 cfg.one_high : cfg.zero_high);
            end
            if (sending_next) begin
                level = in_high_next;
                if (ticks_next > TICK_W'(1)) begin
                    ticks_next = ticks_next - 1'b1;
                end else if (in_high_next) begin
                    in_high_next = 1'b0;
                    if (bit_left_next == '0) begin
                        ticks_next = at_least_one(shift_byte_next[BYTE_W-1] ?
                                                  cfg.one_low_last : cfg.zero_low_last);
                    end else begin
                        ticks_next = at_least_one(shift_byte_next[BYTE_W-1] ?
                                                  cfg.one_low : cfg.zero_low);
                    end
                end else if (bit_left_next == '0) begin
                    sending_next      = 1'b0;
                    ticks_next        = '0;
                    done              = sending_last_next;
                    sending_last_next = 1'b0;
                end else begin
                    bit_left_next   = bit_left_next - 1'b1;
                    in_high_next    = 1'b1;
                    ticks_next      = at_least_one(shift_byte_next[BYTE_W-2] ?
                                                   cfg.one_high : cfg.zero_high);
                    shift_byte_next = {shift_byte_next[BYTE_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_byte_reg   <= '0;
            bit_left_reg     <= '0;
            in_high_reg      <= 1'b0;
            ticks_reg        <= '0;
            sending_reg      <= 1'b0;
            sending_last_reg <= 1'b0;
            pend_full_reg    <= 1'b0;
            pend_last_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                shift_byte_reg   <= shift_byte_next;
                bit_left_reg     <= bit_left_next;
                in_high_reg      <= in_high_next;
                ticks_reg        <= ticks_next;
                sending_reg      <= sending_next;
                sending_last_reg <= sending_last_next;
                pend_full_reg    <= pend_full_next;
                pend_last_reg    <= pend_last_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            pend_byte_reg    <= pend_byte_next;
            m_line_level_reg <= level;
            m_accepted_reg   <= acc;
            m_busy_res_reg   <= sending_next | pend_full_next;
            m_frame_done_reg <= done;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_line_level = m_line_level_reg;
    assign m_accepted   = m_accepted_reg;
    assign m_busy_res   = m_busy_res_reg;
    assign m_frame_done = m_frame_done_reg;

    a_idle_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !sending_reg |-> ticks_reg == '0)
        else $error("phase count left over on idle line");

    a_send_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        sending_reg |-> ticks_reg != '0)
        else $error("active phase with zero ticks");

    a_done_low: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(q_pop) && m_frame_done_reg |-> !m_line_level_reg && m_accepted_reg)
        else $error("frame end reported outside a low gap");

    a_refused_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(q_pop) && !m_accepted_reg |-> m_busy_res_reg && !m_line_level_reg)
        else $error("refused load while holding register empty");

endmodule

[rtl/led_pulse_width_serializer_unit.sv]
// ----------------------------------------------------------------------------
// led_pulse_width_serializer_unit
// Single-wire LED data encoder: color bytes out MSB first as timed pulses.
// ----------------------------------------------------------------------------
// A result passes the queue entry, then the engine's registered output, and
// is held there while m_ready is low.
// Throughput: one item per cycle while the output is not stalled, set by the
// engine updating its shifter and phase counter for each item; s_ready drops
// only when the 2-entry queue fills behind a stalled output.
// Reset (aresetn, synchronous): line idle, holding register empty, queue and
// output channel empty, timing registers back to their defaults.
module led_pulse_width_serializer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [lpws_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_line_level,
    output logic                          m_accepted,
    output logic                          m_busy_res,
    output logic                          m_frame_done,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpws_pkg::APB_AW-1:0]   paddr,
    input  logic [lpws_pkg::APB_DW-1:0]   pwdata,
    output logic [lpws_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import lpws_pkg::*;

    cfg_t               cfg_reg, cfg_next;
    logic [REGIDX_W-1:0] reg_idx;
    logic [TICK_W-1:0]  wval;
    logic [TICK_W-1:0]  rval;
    logic               wr_en;
    logic               q_valid;
    logic               q_pop;
    cmd_t               q_cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wval    = pwdata[TICK_W-1:0];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_ONE_HIGH:      cfg_next.one_high      = wval;
                REG_ONE_LOW:       cfg_next.one_low       = wval;
                REG_ONE_LOW_LAST:  cfg_next.one_low_last  = wval;
                REG_ZERO_HIGH:     cfg_next.zero_high     = wval;
                REG_ZERO_LOW:      cfg_next.zero_low      = wval;
                REG_ZERO_LOW_LAST: cfg_next.zero_low_last = wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ONE_HIGH:      rval = cfg_reg.one_high;
            REG_ONE_LOW:       rval = cfg_reg.one_low;
            REG_ONE_LOW_LAST:  rval = cfg_reg.one_low_last;
            REG_ZERO_HIGH:     rval = cfg_reg.zero_high;
            REG_ZERO_LOW:      rval = cfg_reg.zero_low;
            REG_ZERO_LOW_LAST: rval = cfg_reg.zero_low_last;
            default:           rval = '0;
        endcase
    end

    assign prdata = APB_DW'(rval);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_high      <= RST_ONE_HIGH;
            cfg_reg.one_low       <= RST_ONE_LOW;
            cfg_reg.one_low_last  <= RST_ONE_LOW_LAST;
            cfg_reg.zero_high     <= RST_ZERO_HIGH;
            cfg_reg.zero_low      <= RST_ZERO_LOW;
            cfg_reg.zero_low_last <= RST_ZERO_LOW_LAST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lpws_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop)
    );

    lpws_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_level (m_line_level),
        .m_accepted   (m_accepted),
        .m_busy_res   (m_busy_res),
        .m_frame_done (m_frame_done)
    );

endmodule
